// File: hdl/bbc_pkg.sv
// Package for the block buffer cache tag manager.
// Holds the request, response and slot entry types, codes and sequencer states.
// No dependencies.
package bbc_pkg;

   localparam int NUM_SLOTS_DEF = 32;

   // request operation codes
   localparam logic [1:0] OP_GET     = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_PIN     = 2'd2;
   localparam logic [1:0] OP_UNPIN   = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FREE   = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_OVERFLOW  = 2'd3;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  device;
      logic [31:0] block_number;
      logic [4:0]  buffer_slot;
      logic [31:0] now_tick;
   } req_type;

   typedef struct packed {
      logic [4:0] slot;
      logic       was_cached;
      logic       must_read_disk;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic        holds_block;
      logic [7:0]  tag_device;
      logic [31:0] tag_block;
      logic [7:0]  ref_count;
      logic [31:0] release_time;
   } entry_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SINGLE,
      S_RDWAIT,
      S_FIN
   } state_type;

endpackage

// File: hdl/bbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/block_buffer_cache_lru.sv
// Block buffer cache tag manager: slot tags, reference counts and release ticks in one RAM.
// Get: one read pass over all NUM_SLOTS entries, then a decide step, then the response.
// Release, pin, unpin: read, modify, write one entry; a slot beyond the table is answered without a read.
// One request at a time: req_ready is high only in the idle state, reached once the last result is handed over.
// After reset a clearing pass writes every entry to zero, req_ready low.
// Depends on bbc_pkg and bbc_ram.
module block_buffer_cache_lru #(
   parameter int NUM_SLOTS = bbc_pkg::NUM_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bbc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bbc_pkg::rsp_type rsp_data
);

   import bbc_pkg::*;

   localparam int AW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int EW = $bits(entry_type);
   localparam logic [CW-1:0] CNT_END  = CW'(NUM_SLOTS);
   localparam logic [CW-1:0] CNT_LAST = CW'(NUM_SLOTS - 1);

   // report a slot index in the 5-bit response field
   function automatic logic [4:0] slot5(input logic [AW-1:0] idx);
      logic [31:0] w;
      w = 32'(idx);
      return w[4:0];
   endfunction

   state_type       state_ff, state_in;
   req_type         req_ff, req_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rd_valid_ff, rd_valid_in;
   logic [AW-1:0]   rd_idx_ff, rd_idx_in;

   // search results of the get pass
   logic            hit_found_ff, hit_found_in;
   logic [AW-1:0]   hit_idx_ff, hit_idx_in;
   logic [7:0]      hit_cnt_ff, hit_cnt_in;
   logic [31:0]     hit_time_ff, hit_time_in;
   logic            best_found_ff, best_found_in;
   logic [AW-1:0]   best_idx_ff, best_idx_in;
   logic [31:0]     best_time_ff, best_time_in;

   // pending write-back and result
   logic            wr_pend_ff, wr_pend_in;
   logic [AW-1:0]   wr_addr_ff, wr_addr_in;
   entry_type       wr_data_ff, wr_data_in;
   rsp_type         res_ff, res_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   // RAM port signals
   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [EW-1:0]   ram_wdata;
   logic [AW-1:0]   ram_raddr;
   logic [EW-1:0]   ram_rdata;
   entry_type       rd_entry;

   logic [31:0]     bs_wide;
   logic [AW-1:0]   bs_addr;
   logic            bs_in_range;
   logic            req_fire;
   logic            fin_fire;
   logic            scan_issue;

   assign bs_wide     = 32'(req_ff.buffer_slot);
   assign bs_addr     = bs_wide[AW-1:0];
   assign bs_in_range = (bs_wide < NUM_SLOTS);
   assign req_fire    = req_valid && req_ready;
   // hand the result over only once the response register is free
   assign fin_fire    = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
   assign scan_issue  = (state_ff == S_SCAN) && (cnt_ff < CNT_END);
   assign rd_entry    = entry_type'(ram_rdata);

   bbc_ram #(
      .WIDTH(EW),
      .DEPTH(NUM_SLOTS)
   ) u_slots (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.op == OP_GET) ? S_SCAN : S_SINGLE;
            end
         end
         S_SCAN: begin
            // leave once every read has been issued and the last one seen
            if ((cnt_ff == CNT_END) && !rd_valid_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: state_in = S_FIN;
         S_SINGLE: state_in = bs_in_range ? S_RDWAIT : S_FIN;
         S_RDWAIT: state_in = S_FIN;
         S_FIN: begin
            if (fin_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // outputs and RAM port control
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      ram_we    = 1'b0;
      ram_waddr = wr_addr_ff;
      ram_wdata = wr_data_ff;
      ram_raddr = bs_addr;
      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[AW-1:0];
            ram_wdata = '0;
         end
         S_SCAN: ram_raddr = cnt_ff[AW-1:0];
         S_FIN:  ram_we    = fin_fire && wr_pend_ff;
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      rd_valid_in   = scan_issue;
      rd_idx_in     = cnt_ff[AW-1:0];
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_cnt_in    = hit_cnt_ff;
      hit_time_in   = hit_time_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_time_in  = best_time_ff;
      wr_pend_in    = wr_pend_ff;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      res_in        = res_ff;

      case (state_ff)
         S_CLEAR: cnt_in = cnt_ff + 1'b1;
         S_IDLE: begin
            if (req_fire) begin
               req_in        = req_data;
               cnt_in        = '0;
               hit_found_in  = 1'b0;
               best_found_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (scan_issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               // first matching tag wins
               if (!hit_found_ff && rd_entry.holds_block
                   && (rd_entry.tag_device == req_ff.device)
                   && (rd_entry.tag_block == req_ff.block_number)) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_cnt_in   = rd_entry.ref_count;
                  hit_time_in  = rd_entry.release_time;
               end
               // oldest free slot, strict compare keeps the lowest on ties
               if ((rd_entry.ref_count == 8'd0)
                   && (!best_found_ff || (rd_entry.release_time < best_time_ff))) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_time_in  = rd_entry.release_time;
               end
            end
         end
         S_DECIDE: begin
            wr_data_in.holds_block = 1'b1;
            wr_data_in.tag_device  = req_ff.device;
            wr_data_in.tag_block   = req_ff.block_number;
            if (hit_found_ff) begin
               wr_pend_in                = (hit_cnt_ff != COUNT_MAX);
               wr_addr_in                = hit_idx_ff;
               wr_data_in.ref_count      = hit_cnt_ff + 8'd1;
               wr_data_in.release_time   = hit_time_ff;
               res_in.slot               = slot5(hit_idx_ff);
               res_in.was_cached         = 1'b1;
               res_in.must_read_disk     = 1'b0;
               res_in.status = (hit_cnt_ff == COUNT_MAX) ? ST_OVERFLOW : ST_OK;
            end else if (best_found_ff) begin
               // retag the victim, keep its release tick
               wr_pend_in              = 1'b1;
               wr_addr_in              = best_idx_ff;
               wr_data_in.ref_count    = 8'd1;
               wr_data_in.release_time = best_time_ff;
               res_in.slot             = slot5(best_idx_ff);
               res_in.was_cached       = 1'b0;
               res_in.must_read_disk   = 1'b1;
               res_in.status           = ST_OK;
            end else begin
               wr_pend_in            = 1'b0;
               res_in.slot           = 5'd0;
               res_in.was_cached     = 1'b0;
               res_in.must_read_disk = 1'b0;
               res_in.status         = ST_NO_FREE;
            end
         end
         S_SINGLE: begin
            // answer at once for a slot beyond the table; else wait for the read
            wr_pend_in            = 1'b0;
            res_in.slot           = req_ff.buffer_slot;
            res_in.was_cached     = 1'b0;
            res_in.must_read_disk = 1'b0;
            res_in.status = (req_ff.op == OP_PIN) ? ST_OVERFLOW : ST_UNDERFLOW;
         end
         S_RDWAIT: begin
            wr_addr_in = bs_addr;
            wr_data_in = rd_entry;
            res_in.slot           = req_ff.buffer_slot;
            res_in.was_cached     = 1'b0;
            res_in.must_read_disk = 1'b0;
            if (req_ff.op == OP_PIN) begin
               wr_pend_in           = (rd_entry.ref_count != COUNT_MAX);
               wr_data_in.ref_count = rd_entry.ref_count + 8'd1;
               res_in.status = (rd_entry.ref_count == COUNT_MAX) ? ST_OVERFLOW : ST_OK;
            end else begin
               wr_pend_in           = (rd_entry.ref_count != 8'd0);
               wr_data_in.ref_count = rd_entry.ref_count - 8'd1;
               res_in.status = (rd_entry.ref_count == 8'd0) ? ST_UNDERFLOW : ST_OK;
               // stamp the tick on the final release only
               if ((req_ff.op == OP_RELEASE) && (rd_entry.ref_count == 8'd1)) begin
                  wr_data_in.release_time = req_ff.now_tick;
               end
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cnt_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         hit_found_ff  <= 1'b0;
         best_found_ff <= 1'b0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_valid_ff   <= rd_valid_in;
         hit_found_ff  <= hit_found_in;
         best_found_ff <= best_found_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff       <= req_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_cnt_ff   <= hit_cnt_in;
      hit_time_ff  <= hit_time_in;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      wr_addr_ff   <= wr_addr_in;
      wr_data_ff   <= wr_data_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// File: verif/block_buffer_cache_lru_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the block buffer cache tag manager.
// Drives get, release, pin and unpin requests and checks every response against its own predictor.
// Depends on bbc_pkg and block_buffer_cache_lru.
module block_buffer_cache_lru_tb;
   import bbc_pkg::*;

   localparam int NUM_SLOTS = NUM_SLOTS_DEF;
   localparam int POOL_SIZE = 48;
   // Watchdog limit on the run, in clock cycles.
   localparam int unsigned CYCLE_LIMIT = 1000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Predicted slot table, one entry per cache slot.
   logic        cache_valid [NUM_SLOTS];
   logic [7:0]  cache_dev   [NUM_SLOTS];
   logic [31:0] cache_blk   [NUM_SLOTS];
   logic [7:0]  cache_refs  [NUM_SLOTS];
   logic [31:0] cache_stamp [NUM_SLOTS];

   req_type pending_req [$];   // requests waiting for the driver
   rsp_type expected_rsp [$];  // predicted responses, oldest first

   // Tags reused by gets so that hits are common.
   logic [7:0]  pool_dev [POOL_SIZE];
   logic [31:0] pool_blk [POOL_SIZE];

   int unsigned send_idle_pct = 22;
   int unsigned recv_idle_pct = 72;
   int unsigned requests_made = 0;
   int unsigned requests_taken = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   logic [31:0] tick_base = 32'd100;

   int unsigned seen_hit = 0;
   int unsigned seen_miss = 0;
   int unsigned seen_no_free = 0;
   int unsigned seen_overflow = 0;
   int unsigned seen_underflow = 0;

   block_buffer_cache_lru #(
      .NUM_SLOTS(NUM_SLOTS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one request to the predicted slot table and return the response it earns.
   function automatic rsp_type predict_access(input req_type r);
      rsp_type res;
      int      hit_slot;
      int      victim;
      int      bs;
      res = '0;
      hit_slot = -1;
      victim = -1;
      bs = int'(r.buffer_slot);
      if (r.op == OP_GET) begin
         // An empty slot never hits, even with a matching stale tag.
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (hit_slot < 0 && cache_valid[i] && cache_dev[i] == r.device
                && cache_blk[i] == r.block_number) begin
               hit_slot = i;
            end
         end
         if (hit_slot >= 0) begin
            res.slot = 5'(hit_slot);
            res.was_cached = 1'b1;
            if (cache_refs[hit_slot] == COUNT_MAX) begin
               res.status = ST_OVERFLOW;
            end else begin
               cache_refs[hit_slot] = cache_refs[hit_slot] + 8'd1;
               res.status = ST_OK;
            end
         end else begin
            // Oldest release tick among unreferenced slots; strict compare keeps the lowest.
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (cache_refs[i] == 8'd0
                   && (victim < 0 || cache_stamp[i] < cache_stamp[victim])) begin
                  victim = i;
               end
            end
            if (victim < 0) begin
               res.status = ST_NO_FREE;
            end else begin
               cache_valid[victim] = 1'b1;
               cache_dev[victim] = r.device;
               cache_blk[victim] = r.block_number;
               cache_refs[victim] = 8'd1;
               res.slot = 5'(victim);
               res.must_read_disk = 1'b1;
               res.status = ST_OK;
            end
         end
      end else begin
         res.slot = r.buffer_slot;
         if (bs >= NUM_SLOTS) begin
            res.status = (r.op == OP_PIN) ? ST_OVERFLOW : ST_UNDERFLOW;
         end else if (r.op == OP_PIN) begin
            if (cache_refs[bs] == COUNT_MAX) begin
               res.status = ST_OVERFLOW;
            end else begin
               cache_refs[bs] = cache_refs[bs] + 8'd1;
               res.status = ST_OK;
            end
         end else if (cache_refs[bs] == 8'd0) begin
            res.status = ST_UNDERFLOW;
         end else begin
            cache_refs[bs] = cache_refs[bs] - 8'd1;
            // Only a release to zero stamps the tick; unpin to zero leaves it.
            if (r.op == OP_RELEASE && cache_refs[bs] == 8'd0) begin
               cache_stamp[bs] = r.now_tick;
            end
            res.status = ST_OK;
         end
      end
      return res;
   endfunction

   // Mix of extremes, small values for tie breaks, rising ticks and noise.
   function automatic logic [31:0] pick_tick();
      int unsigned sel;
      sel = $urandom_range(9);
      tick_base = tick_base + 32'($urandom_range(1, 5));
      case (sel)
         0: begin
            return 32'd0;
         end
         1: begin
            return 32'hFFFF_FFFF;
         end
         2, 3: begin
            return 32'($urandom_range(3));
         end
         4: begin
            return $urandom();
         end
         default: begin
            return tick_base;
         end
      endcase
   endfunction

   // Prefer a slot the predictor sees as referenced; fall back to any slot.
   function automatic logic [4:0] pick_busy_slot();
      int busy [$];
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (cache_refs[i] != 8'd0) busy.push_back(i);
      end
      if (busy.size() == 0 || $urandom_range(9) == 0) return 5'($urandom_range(31));
      return 5'(busy[$urandom_range(busy.size() - 1)]);
   endfunction

   // Queue one request, keeping the queue short so that shaping sees recent state.
   task automatic push_request(input logic [1:0] op, input logic [7:0] dev,
                               input logic [31:0] blk, input logic [4:0] bslot,
                               input logic [31:0] tick);
      req_type r;
      r.op = op;
      r.device = dev;
      r.block_number = blk;
      r.buffer_slot = bslot;
      r.now_tick = tick;
      while (pending_req.size() >= 2) @(negedge clock);
      pending_req.push_back(r);
      requests_made++;
      // Shift the idling pattern in three stages.
      if (requests_made < 800) begin
         send_idle_pct = 22;
         recv_idle_pct = 72;
      end else if (requests_made < 1600) begin
         send_idle_pct = 72;
         recv_idle_pct = 22;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // Hold until every request has gone in and every response has come back.
   task automatic wait_drained();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Watchdog: end the run if it overstays the limit.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Driver: offer the next pending request, hold it until accepted, predict on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_access(req_data));
            requests_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_req.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted response, then decide the next cycle's ready.
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding: slot %0d status %0d",
                      rsp_data.slot, rsp_data.status);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_data.slot);
                  fail_count++;
               end
               if (rsp_data.was_cached !== want.was_cached) begin
                  $error("was_cached: expected %0d, got %0d", want.was_cached,
                         rsp_data.was_cached);
                  fail_count++;
               end
               if (rsp_data.must_read_disk !== want.must_read_disk) begin
                  $error("must_read_disk: expected %0d, got %0d", want.must_read_disk,
                         rsp_data.must_read_disk);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (want.was_cached) seen_hit++;
               if (want.must_read_disk) seen_miss++;
               if (want.status == ST_NO_FREE) seen_no_free++;
               if (want.status == ST_OVERFLOW) seen_overflow++;
               if (want.status == ST_UNDERFLOW) seen_underflow++;
            end
         end
         // Once in the run, starve the response side long enough to back up the input.
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && requests_taken >= 600) begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Stimulus: directed opening, random scenarios, one overflow run, then drain and report.
   initial begin
      int unsigned scenario;
      int unsigned k;
      int          target;
      int          held [$];

      for (int i = 0; i < NUM_SLOTS; i++) begin
         cache_valid[i] = 1'b0;
         cache_dev[i] = 8'd0;
         cache_blk[i] = 32'd0;
         cache_refs[i] = 8'd0;
         cache_stamp[i] = 32'd0;
      end
      pool_dev[0] = 8'h00;
      pool_blk[0] = 32'h0000_0000;
      pool_dev[1] = 8'hFF;
      pool_blk[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) begin
         pool_dev[i] = 8'($urandom_range(255));
         pool_blk[i] = (i % 3 == 0) ? 32'($urandom_range(15)) : $urandom();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening.
      push_request(OP_UNPIN, 8'h00, 32'h0, 5'd0, 32'h0);            // count already zero
      push_request(OP_RELEASE, 8'h00, 32'h0, 5'd31, 32'h0);         // count already zero
      push_request(OP_GET, 8'h00, 32'h0000_0000, 5'd0, 32'h0);      // zero tag, empty slot: miss
      push_request(OP_GET, 8'h00, 32'h0000_0000, 5'd0, 32'h0);      // hit
      push_request(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'h0);     // miss
      push_request(OP_PIN, 8'h00, 32'h0, 5'd31, 32'h0);             // pin an empty slot
      push_request(OP_UNPIN, 8'h00, 32'h0, 5'd31, 32'hFFFF_FFFF);   // unpin to zero, no stamp
      push_request(OP_PIN, 8'h00, 32'h0, 5'd30, 32'h0);
      push_request(OP_UNPIN, 8'h00, 32'h0, 5'd30, 32'h0);
      push_request(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'hFFFF_FFFF);
      push_request(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'hFFFF_FFFF);  // final release, late stamp
      push_request(OP_RELEASE, 8'h00, 32'h0, 5'd1, 32'h0);          // final release, stamp zero
      push_request(OP_GET, 8'h5A, 32'h1234_5678, 5'd0, 32'h0);      // tie goes to lowest slot
      push_request(OP_GET, 8'h00, 32'h0000_0000, 5'd0, 32'h0);      // hit on unreferenced slot
      push_request(OP_UNPIN, 8'h00, 32'h0, 5'd0, 32'h0);
      push_request(OP_GET, 8'hA5, 32'h8000_0001, 5'd0, 32'h0);
      push_request(OP_GET, 8'hFF, 32'hFFFF_FFFE, 5'd0, 32'h0);      // near miss on block
      push_request(OP_GET, 8'hFE, 32'hFFFF_FFFF, 5'd0, 32'h0);      // near miss on device
      push_request(OP_PIN, 8'h00, 32'h0, 5'd1, 32'h0);
      push_request(OP_RELEASE, 8'h00, 32'h0, 5'd1, 32'h7FFF_FFFF);

      // Random scenarios.
      while (requests_made < 2000) begin
         if (requests_made >= 900 && requests_made < 1000) begin
            // Drive one slot to the count limit, hit it there, then unwind past zero.
            wait_drained();
            held.delete();
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (cache_valid[i]) held.push_back(i);
            end
            target = (held.size() != 0) ? held[$urandom_range(held.size() - 1)]
                                        : $urandom_range(NUM_SLOTS - 1);
            repeat (256) push_request(OP_PIN, 8'($urandom()), $urandom(), 5'(target),
                                      $urandom());
            push_request(OP_GET, cache_dev[target], cache_blk[target], 5'(target), 32'h0);
            repeat (250) push_request(OP_UNPIN, 8'($urandom()), $urandom(), 5'(target),
                                      pick_tick());
            repeat (7) push_request(OP_RELEASE, 8'($urandom()), $urandom(), 5'(target),
                                    pick_tick());
         end
         scenario = $urandom_range(9);
         case (scenario)
            6, 7: begin
               // Fill every slot with fresh tags until gets are refused, then free them.
               repeat (34) push_request(OP_GET, 8'($urandom()), $urandom(),
                                        5'($urandom()), $urandom());
               k = $urandom_range(3);
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (cache_refs[i] != 8'd0) begin
                     push_request(OP_RELEASE, 8'($urandom()), $urandom(), 5'(i),
                                  ($urandom_range(1) == 0) ? 32'(k) : pick_tick());
                  end
               end
            end
            8: begin
               // Noise: every field random.
               repeat (10) push_request(2'($urandom()), 8'($urandom()), $urandom(),
                                        5'($urandom()), $urandom());
            end
            9: begin
               repeat (20) begin
                  k = $urandom_range(POOL_SIZE - 1);
                  push_request(OP_GET, pool_dev[k], pool_blk[k], 5'($urandom()), $urandom());
               end
            end
            default: begin
               // Balanced traffic: gets mostly from the pool, counts moved on busy slots.
               repeat (30) begin
                  k = $urandom_range(99);
                  if (k < 45) begin
                     if ($urandom_range(9) < 7) begin
                        k = $urandom_range(POOL_SIZE - 1);
                        push_request(OP_GET, pool_dev[k], pool_blk[k], 5'($urandom()),
                                     $urandom());
                     end else begin
                        push_request(OP_GET, 8'($urandom()), $urandom(), 5'($urandom()),
                                     $urandom());
                     end
                  end else if (k < 75) begin
                     push_request(OP_RELEASE, 8'($urandom()), $urandom(), pick_busy_slot(),
                                  pick_tick());
                  end else if (k < 86) begin
                     push_request(OP_PIN, 8'($urandom()), $urandom(), pick_busy_slot(),
                                  pick_tick());
                  end else if (k < 97) begin
                     push_request(OP_UNPIN, 8'($urandom()), $urandom(), pick_busy_slot(),
                                  pick_tick());
                  end else begin
                     push_request(2'($urandom()), 8'($urandom()), $urandom(),
                                  5'($urandom()), $urandom());
                  end
               end
            end
         endcase
      end

      wait_drained();
      // Leave room for any stray response beyond the longest scan.
      repeat (3 * NUM_SLOTS) @(negedge clock);

      $display("Ran %0d requests: %0d hits, %0d disk reads, %0d refused for want of a slot,",
               requests_taken, seen_hit, seen_miss, seen_no_free);
      $display("  %0d count overflows and %0d count underflows, with %0d mismatches.",
               seen_overflow, seen_underflow, fail_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
